[sv/assert_macros.svh]
// Assertion helpers shared by the stack core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define BSWS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define BSWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/bsws_pkg.sv]
`timescale 1ns / 1ps

package bsws_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int VALUE_W      = 32;
  localparam int OP_W         = 2;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_TUSER_W  = 3;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SORT = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_SORT = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[sv/bounded_stack_with_sort_core.sv]
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit values with an in-place descending sort.
// The input channel (in_*) carries one command per transaction: in_tuser holds the
// operation (push, pop or sort) and in_tdata the value to push. Every command
// returns exactly one result transaction on the output channel (out_*), in order.
// Commands enter a two-entry queue and are carried out one at a time by an
// execution unit that holds the entries in a RAM with one write and one read port
// and the top entry in a register. A push, an error, a sort of one entry or a pop
// of the last entry is done in state IDLE; any other pop also passes through
// LOAD_TOP, since the new top is read back from the RAM. A sort of n entries is a
// bubble sort through the RAM read port. A command is registered in the queue and
// its result in the output register, which presents it. Reset empties the stack and
// the queue and drops any pending result.
// When the receiver stalls, the result waits in the output register and the
// execution unit holds the next command (a running sort goes on until its result
// is ready), while the queue keeps taking commands until it holds two; then
// in_tready falls.
module bounded_stack_with_sort_core #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] push_value
  input  logic [bsws_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [bsws_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] data_value, [32] is_empty, [37:33] entry_count, [42:38] odd_count, [47:43] zero
  output logic [bsws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] data_valid, [2:1] status
  output logic [bsws_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  logic           q_valid;
  logic           q_ready;
  bsws_pkg::cmd_t q_cmd;

  bsws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  bsws_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[sv/bsws_ram.sv]
`timescale 1ns / 1ps

module bsws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bsws_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsws_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bsws_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [bsws_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               q_valid,
  input  logic                               q_ready,
  output bsws_pkg::cmd_t                     q_cmd
);

  bsws_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           accept;
  logic           deq;
  bsws_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.value = in_tdata[bsws_pkg::VALUE_W-1:0];
    case (in_tuser)
      bsws_pkg::OP_PUSH: cmd_in.kind = bsws_pkg::CMD_PUSH;
      bsws_pkg::OP_POP:  cmd_in.kind = bsws_pkg::CMD_POP;
      bsws_pkg::OP_SORT: cmd_in.kind = bsws_pkg::CMD_SORT;
      default:           cmd_in.kind = bsws_pkg::CMD_NOP;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_cmd     = mem_r[rd_ptr_r];
  assign deq       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (deq) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (accept && !deq) begin
      count_nxt = count_r + 2'd1;
    end else if (deq && !accept) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  `BSWS_ASSERT(a_queue_bound, clk, rst_n, count_r <= 2'd2, "command queue count out of range")

endmodule

[sv/bsws_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsws_back #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  bsws_pkg::cmd_t                     q_cmd,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bsws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [bsws_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = bsws_pkg::VALUE_W;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_LOAD_TOP = 6'b000010,
    ST_SLOAD    = 6'b000100,
    ST_SCMP     = 6'b001000,
    ST_SEND     = 6'b010000,
    ST_REPORT   = 6'b100000
  } st_t;

  st_t                           state_r, state_nxt;
  logic [CW-1:0]                 fill_r, fill_nxt;
  logic [CW-1:0]                 odd_r, odd_nxt;
  logic [VW-1:0]                 top_r, top_nxt;
  logic [VW-1:0]                 cur_r, cur_nxt;
  logic [AW-1:0]                 k_r, k_nxt;
  logic [CW-1:0]                 len_r, len_nxt;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [VW-1:0]                 out_data_r;
  logic                          out_dvalid_r;
  logic                          out_empty_r;
  logic [bsws_pkg::COUNT_W-1:0]  out_count_r;
  logic [bsws_pkg::COUNT_W-1:0]  out_odd_r;
  logic [bsws_pkg::STATUS_W-1:0] out_status_r;

  logic                          res_free;
  logic                          res_load;
  logic [VW-1:0]                 res_data;
  logic                          res_dvalid;
  logic [bsws_pkg::STATUS_W-1:0] res_status;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [VW-1:0]                 ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [VW-1:0]                 ram_rdata;

  logic [CW-1:0]                 fill_m2;
  logic [CW-1:0]                 len_m1;

  assign res_free = !out_tvalid_r || out_tready;
  assign fill_m2  = fill_r - CW'(2);
  assign len_m1   = len_r - CW'(1);

  bsws_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    odd_nxt    = odd_r;
    top_nxt    = top_r;
    cur_nxt    = cur_r;
    k_nxt      = k_r;
    len_nxt    = len_r;
    q_ready    = 1'b0;
    res_load   = 1'b0;
    res_data   = '0;
    res_dvalid = 1'b0;
    res_status = bsws_pkg::STATUS_OK;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && res_free) begin
          q_ready  = 1'b1;
          res_load = 1'b1;
          case (q_cmd.kind)
            bsws_pkg::CMD_PUSH: begin
              if (fill_r == CW'(DEPTH)) begin
                res_status = bsws_pkg::STATUS_OVERFLOW;
                res_data   = top_r;
                res_dvalid = 1'b1;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = fill_r[AW-1:0];
                ram_wdata  = q_cmd.value;
                fill_nxt   = fill_r + CW'(1);
                odd_nxt    = odd_r + CW'(q_cmd.value[0]);
                top_nxt    = q_cmd.value;
                res_data   = q_cmd.value;
                res_dvalid = 1'b1;
              end
            end
            bsws_pkg::CMD_POP: begin
              if (fill_r == '0) begin
                res_status = bsws_pkg::STATUS_EMPTY;
              end else begin
                res_data   = top_r;
                res_dvalid = 1'b1;
                fill_nxt   = fill_r - CW'(1);
                odd_nxt    = odd_r - CW'(top_r[0]);
                if (fill_r > CW'(1)) begin
                  ram_raddr = fill_m2[AW-1:0];
                  state_nxt = ST_LOAD_TOP;
                end
              end
            end
            bsws_pkg::CMD_SORT: begin
              if (fill_r == '0) begin
                res_status = bsws_pkg::STATUS_EMPTY;
              end else if (fill_r == CW'(1)) begin
                res_data   = top_r;
                res_dvalid = 1'b1;
              end else begin
                res_load  = 1'b0;
                ram_raddr = '0;
                len_nxt   = fill_r;
                state_nxt = ST_SLOAD;
              end
            end
            default: begin
              if (fill_r != '0) begin
                res_data   = top_r;
                res_dvalid = 1'b1;
              end
            end
          endcase
        end
      end
      ST_LOAD_TOP: begin
        top_nxt   = ram_rdata;
        state_nxt = ST_IDLE;
      end
      ST_SLOAD: begin
        cur_nxt   = ram_rdata;
        k_nxt     = '0;
        ram_raddr = AW'(1);
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        if ($signed(cur_r) < $signed(ram_rdata)) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        if ((CW'(k_r) + CW'(2)) < len_r) begin
          k_nxt     = k_r + AW'(1);
          ram_raddr = k_r + AW'(2);
        end else begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        ram_we    = 1'b1;
        ram_waddr = len_m1[AW-1:0];
        ram_wdata = cur_r;
        if (len_r == fill_r) begin
          top_nxt = cur_r;
        end
        len_nxt = len_m1;
        if (len_r > CW'(2)) begin
          ram_raddr = '0;
          state_nxt = ST_SLOAD;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (res_free) begin
          res_load   = 1'b1;
          res_data   = top_r;
          res_dvalid = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (res_load) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      odd_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      odd_r        <= odd_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    len_r <= len_nxt;
    if (res_load) begin
      out_data_r   <= res_data;
      out_dvalid_r <= res_dvalid;
      out_status_r <= res_status;
      out_empty_r  <= (fill_nxt == '0);
      out_count_r  <= bsws_pkg::COUNT_W'(fill_nxt);
      out_odd_r    <= bsws_pkg::COUNT_W'(odd_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_odd_r, out_count_r, out_empty_r, out_data_r};
  assign out_tuser  = {out_status_r, out_dvalid_r};

  `BSWS_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CW'(DEPTH), "fill level above depth")
  `BSWS_ASSERT(a_odd_bound, clk, rst_n, odd_r <= fill_r, "odd count above fill level")
  `BSWS_ASSERT(a_sort_keeps_counts, clk, rst_n, (state_r == ST_SCMP || state_r == ST_SEND) |=> ($stable(fill_r) && $stable(odd_r)), "sort changed the counts")

endmodule
